@@ design/rsis_pkg.sv @@
`default_nettype none

package rsis_pkg;

    // Event log geometry
    localparam int LOG_DEPTH = 12;
    localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int LOG_CW    = $clog2(LOG_DEPTH + 1);

    // Field widths
    localparam int KIND_W   = 5;
    localparam int VALUE_W  = 10;
    localparam int LEVEL_W  = 7;
    localparam int POS_W    = 4;
    localparam int CFG_AW   = 3;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 6;
    localparam int OUT_FIELD_W = 44;
    localparam int OUT_TDATA_W = 48;

    // Reset and limit values
    localparam logic [LEVEL_W-1:0] ALIGN_RST      = 7'd85;
    localparam logic [LEVEL_W-1:0] PRESS_RST      = 7'd40;
    localparam logic [LEVEL_W-1:0] ALIGN_MIN_RST  = 7'd60;
    localparam logic [LEVEL_W-1:0] PRESS_MIN_RST  = 7'd20;
    localparam logic [LEVEL_W-1:0] PRESS_MAX_RST  = 7'd80;
    localparam logic [LEVEL_W-1:0] FUEL_STEP_RST  = 7'd5;
    localparam logic [LEVEL_W-1:0] FUEL_FULL_RST  = 7'd100;
    localparam logic [VALUE_W-2:0] SETTING_MAX    = 9'd100;

    typedef enum logic [KIND_W-1:0] {
        K_TICK        = 5'd0,
        K_PING        = 5'd1,
        K_STATUS      = 5'd2,
        K_LOG         = 5'd3,
        K_RESET       = 5'd4,
        K_SET_ALIGN   = 5'd5,
        K_SET_PRESS   = 5'd6,
        K_ABORT       = 5'd7,
        K_INJECT      = 5'd8,
        K_APPROACH    = 5'd9,
        K_CHECK_ALIGN = 5'd10,
        K_LOCK        = 5'd11,
        K_OPEN_GATE   = 5'd12,
        K_CHECK_PRESS = 5'd13,
        K_START       = 5'd14,
        K_STOP        = 5'd15,
        K_EMPTY       = 5'd16,
        K_INVALID     = 5'd17
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE     = 4'd0,
        MODE_APPROACH = 4'd1,
        MODE_ALIGN    = 4'd2,
        MODE_DOCKED   = 4'd3,
        MODE_GATE     = 4'd4,
        MODE_PRESS    = 4'd5,
        MODE_REFUEL   = 4'd6,
        MODE_COMPLETE = 4'd7,
        MODE_ABORT    = 4'd8,
        MODE_SAFE     = 4'd9,
        MODE_FAULT    = 4'd10
    } mode_t;

    typedef enum logic [4:0] {
        RESP_NONE           = 5'd0,
        RESP_PING           = 5'd1,
        RESP_LOG            = 5'd2,
        RESP_RESET          = 5'd3,
        RESP_ALIGN_SET      = 5'd4,
        RESP_ALIGN_NO_VALUE = 5'd5,
        RESP_ALIGN_RANGE    = 5'd6,
        RESP_PRESS_SET      = 5'd7,
        RESP_PRESS_NO_VALUE = 5'd8,
        RESP_PRESS_RANGE    = 5'd9,
        RESP_ABORTED        = 5'd10,
        RESP_FAULTED        = 5'd11,
        RESP_REFUSED        = 5'd12,
        RESP_APPROACH       = 5'd13,
        RESP_BAD_TRANSITION = 5'd14,
        RESP_NEED_APPROACH  = 5'd15,
        RESP_ALIGN_OK       = 5'd16,
        RESP_NEED_ALIGN     = 5'd17,
        RESP_LOCKED         = 5'd18,
        RESP_GATE_BLOCKED   = 5'd19,
        RESP_GATE_OPEN      = 5'd20,
        RESP_NEED_GATE_OPEN = 5'd21,
        RESP_PRESS_OK       = 5'd22,
        RESP_NEED_PRESS     = 5'd23,
        RESP_NEED_DOCK      = 5'd24,
        RESP_NEED_GATE      = 5'd25,
        RESP_REFUEL_START   = 5'd26,
        RESP_NOT_REFUELING  = 5'd27,
        RESP_STOPPED        = 5'd28,
        RESP_COMPLETE       = 5'd29,
        RESP_EMPTY          = 5'd30,
        RESP_INVALID        = 5'd31
    } resp_t;

    typedef enum logic [2:0] {
        CAUSE_NONE        = 3'd0,
        CAUSE_ALIGN_LOST  = 3'd1,
        CAUSE_PRESSURE    = 3'd2,
        CAUSE_SUPERVISOR  = 3'd3,
        CAUSE_CUSTOM      = 3'd4,
        CAUSE_MANUAL      = 3'd5,
        CAUSE_ALIGN_RANGE = 3'd6
    } cause_t;

    typedef enum logic [4:0] {
        EV_NONE         = 5'd0,
        EV_BOOT         = 5'd1,
        EV_RESET        = 5'd2,
        EV_APPROACH     = 5'd3,
        EV_ALIGN_OK     = 5'd4,
        EV_DOCKED       = 5'd5,
        EV_GATE_OPEN    = 5'd6,
        EV_PRESS_OK     = 5'd7,
        EV_REFUEL_START = 5'd8,
        EV_REFUEL_STOP  = 5'd9,
        EV_COMPLETE     = 5'd10,
        EV_ABORT_ALIGN  = 5'd11,
        EV_ABORT_PRESS  = 5'd12,
        EV_ABORT_SUPER  = 5'd13,
        EV_ABORT_CUSTOM = 5'd14,
        EV_FAULT_MANUAL = 5'd15,
        EV_FAULT_ALIGN  = 5'd16,
        EV_FAULT_PRESS  = 5'd17
    } event_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_ALIGN_MIN = 3'd0,
        CFG_PRESS_MIN = 3'd1,
        CFG_PRESS_MAX = 3'd2,
        CFG_FUEL_STEP = 3'd3,
        CFG_FUEL_FULL = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEQ_IDLE     = 2'd0,
        SEQ_LOG_RD   = 2'd1,
        SEQ_LOG_WAIT = 2'd2
    } seq_state_t;

    typedef struct packed {
        cause_t              cause;
        logic                gate;
        logic                dock;
        logic [LEVEL_W-1:0]  fuel;
        logic [LEVEL_W-1:0]  press;
        logic [LEVEL_W-1:0]  align;
        mode_t               mode;
    } telem_t;

    typedef struct packed {
        logic   we;
        event_t code;
    } log_wr_t;

endpackage

`default_nettype wire

@@ design/refuel_safety_interlock_sequencer.sv @@
// Refuel safety interlock sequencer. Commands arrive one beat each on the
// s_axis side (kind and has_value in tuser, the signed value in tdata) and
// step the run idle -> approach -> align check -> docked -> gate opened ->
// pressure checked -> refueling -> complete, refusing anything out of order and
// dropping to abort or fault (gate closed) on failed checks. Every command
// except a log request produces one result beat with tlast set; the next
// command is taken in the following cycle as long as the result register is
// free or being drained. A log request reads the event log, a 12-entry
// synchronous memory kept as a ring, and emits one beat per stored entry
// (1 to 12), oldest first: idle takes the request, the log-read state starts
// the read, then one beat per cycle while the sink keeps tready high. Inputs
// are held off during that readout. The log needs no clearing pass after
// reset; only written slots are ever read, the boot entry in slot zero
// coming from a flag. Configuration registers (cfg_addr 0..4: alignment_min,
// pressure_min, pressure_max, fuel_step, fuel_full) are written with cfg_wen;
// the user must do so only while idle, as the block itself does not enforce it.
`default_nettype none

module refuel_safety_interlock_sequencer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // command beat
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [rsis_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // value[9:0], zero pad
    input  wire logic [rsis_pkg::IN_TUSER_W-1:0]     s_axis_tuser,   // kind[4:0], has_value[5]
    // result beat
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // response[4:0], mode[8:5], alignment_now[15:9], pressure_now[22:16],
    // fuel_level[29:23], dock_lock[30], gate_is_open[31], fault_cause[34:32],
    // log_entry[39:35], log_position[43:40], zero pad
    output logic [rsis_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                     m_axis_tlast,
    // configuration
    input  wire logic                                cfg_wen,
    input  wire logic [rsis_pkg::CFG_AW-1:0]         cfg_addr,
    input  wire logic [rsis_pkg::LEVEL_W-1:0]        cfg_wdata
);

    rsis_pkg::seq_state_t              state_reg;
    rsis_pkg::seq_state_t              state_next;
    logic [rsis_pkg::LOG_CW-1:0]       idx_reg;
    logic [rsis_pkg::LOG_CW-1:0]       idx_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic [rsis_pkg::OUT_FIELD_W-1:0]  m_data_reg;
    logic [rsis_pkg::OUT_FIELD_W-1:0]  m_data_next;
    logic                              m_last_reg;
    logic                              m_last_next;

    logic                              in_acc;
    logic                              is_log;
    logic                              out_free;
    logic                              log_last;
    logic                              step;
    logic                              rd_en;
    logic                              load_log;
    logic [rsis_pkg::LOG_AW-1:0]       rd_idx;

    rsis_pkg::telem_t                  telem_now;
    rsis_pkg::telem_t                  telem_next;
    rsis_pkg::resp_t                   resp;
    rsis_pkg::log_wr_t                 log_wr;
    rsis_pkg::event_t                  rd_data;
    logic [rsis_pkg::LOG_CW-1:0]       count;

    rsis_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .kind       (s_axis_tuser[rsis_pkg::KIND_W-1:0]),
        .value      (s_axis_tdata[rsis_pkg::VALUE_W-1:0]),
        .has_value  (s_axis_tuser[rsis_pkg::KIND_W]),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .telem_now  (telem_now),
        .telem_next (telem_next),
        .resp       (resp),
        .log_wr     (log_wr)
    );

    rsis_log u_log (
        .clk     (clk),
        .rst_n   (rst_n),
        .log_wr  (log_wr),
        .rd_en   (rd_en),
        .rd_idx  (rd_idx),
        .rd_data (rd_data),
        .count   (count)
    );

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign is_log   = (s_axis_tuser[rsis_pkg::KIND_W-1:0] == 5'(rsis_pkg::K_LOG));
    assign out_free = !m_valid_reg || m_axis_tready;
    assign log_last = ((idx_reg + rsis_pkg::LOG_CW'(1)) == count);

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsis_pkg::SEQ_IDLE:
            begin
                if (in_acc && is_log)
                    state_next = rsis_pkg::SEQ_LOG_RD;
            end
            rsis_pkg::SEQ_LOG_RD:
            begin
                state_next = rsis_pkg::SEQ_LOG_WAIT;
            end
            rsis_pkg::SEQ_LOG_WAIT:
            begin
                if (out_free && log_last)
                    state_next = rsis_pkg::SEQ_IDLE;
            end
            default:
            begin
                state_next = rsis_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        load_log      = 1'b0;
        rd_idx        = rsis_pkg::LOG_AW'(idx_reg);
        idx_next      = idx_reg;
        unique case (state_reg)
            rsis_pkg::SEQ_IDLE:
            begin
                s_axis_tready = out_free;
                if (in_acc && is_log)
                    idx_next = '0;
            end
            rsis_pkg::SEQ_LOG_RD:
            begin
                rd_en = 1'b1;
            end
            rsis_pkg::SEQ_LOG_WAIT:
            begin
                // hand the current entry over and start the next read at once
                load_log = out_free;
                if (out_free && !log_last)
                begin
                    rd_en    = 1'b1;
                    rd_idx   = rsis_pkg::LOG_AW'(idx_reg + rsis_pkg::LOG_CW'(1));
                    idx_next = idx_reg + rsis_pkg::LOG_CW'(1);
                end
            end
            default: ;
        endcase
        step = in_acc && !is_log;
    end

    // Result register
    always_comb
    begin
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (step)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {rsis_pkg::POS_W'(0), rsis_pkg::EV_NONE, telem_next, resp};
            m_last_next  = 1'b1;
        end
        else if (load_log)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {rsis_pkg::POS_W'(idx_reg), rd_data, telem_now, rsis_pkg::RESP_LOG};
            m_last_next  = log_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rsis_pkg::SEQ_IDLE;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {(rsis_pkg::OUT_TDATA_W - rsis_pkg::OUT_FIELD_W)'(0), m_data_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

@@ design/rsis_core.sv @@
`default_nettype none

module rsis_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step,
    input  wire logic [rsis_pkg::KIND_W-1:0]       kind,
    input  wire logic [rsis_pkg::VALUE_W-1:0]      value,
    input  wire logic                              has_value,
    input  wire logic                              cfg_wen,
    input  wire logic [rsis_pkg::CFG_AW-1:0]       cfg_addr,
    input  wire logic [rsis_pkg::LEVEL_W-1:0]      cfg_wdata,
    output rsis_pkg::telem_t                       telem_now,
    output rsis_pkg::telem_t                       telem_next,
    output rsis_pkg::resp_t                        resp,
    output rsis_pkg::log_wr_t                      log_wr
);

    rsis_pkg::telem_t              telem_reg;
    logic [rsis_pkg::LEVEL_W-1:0]  align_min_reg;
    logic [rsis_pkg::LEVEL_W-1:0]  press_min_reg;
    logic [rsis_pkg::LEVEL_W-1:0]  press_max_reg;
    logic [rsis_pkg::LEVEL_W-1:0]  fuel_step_reg;
    logic [rsis_pkg::LEVEL_W-1:0]  fuel_full_reg;

    rsis_pkg::kind_t               k;
    logic                          align_low;
    logic                          press_bad;
    logic                          locked_out;
    logic                          value_ok;
    logic [rsis_pkg::LEVEL_W:0]    fuel_sum;
    logic                          ev_we;
    rsis_pkg::event_t              ev_code;

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_min_reg <= rsis_pkg::ALIGN_MIN_RST;
            press_min_reg <= rsis_pkg::PRESS_MIN_RST;
            press_max_reg <= rsis_pkg::PRESS_MAX_RST;
            fuel_step_reg <= rsis_pkg::FUEL_STEP_RST;
            fuel_full_reg <= rsis_pkg::FUEL_FULL_RST;
        end
        else if (cfg_wen)
        begin
            case (rsis_pkg::cfg_idx_t'(cfg_addr))
                rsis_pkg::CFG_ALIGN_MIN: align_min_reg <= cfg_wdata;
                rsis_pkg::CFG_PRESS_MIN: press_min_reg <= cfg_wdata;
                rsis_pkg::CFG_PRESS_MAX: press_max_reg <= cfg_wdata;
                rsis_pkg::CFG_FUEL_STEP: fuel_step_reg <= cfg_wdata;
                rsis_pkg::CFG_FUEL_FULL: fuel_full_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            telem_reg.mode  <= rsis_pkg::MODE_IDLE;
            telem_reg.align <= rsis_pkg::ALIGN_RST;
            telem_reg.press <= rsis_pkg::PRESS_RST;
            telem_reg.fuel  <= '0;
            telem_reg.dock  <= 1'b0;
            telem_reg.gate  <= 1'b0;
            telem_reg.cause <= rsis_pkg::CAUSE_NONE;
        end
        else if (step)
        begin
            telem_reg <= telem_next;
        end
    end

    assign telem_now = telem_reg;

    // Command decode and interlocks
    always_comb
    begin
        k          = (kind > 5'(rsis_pkg::K_INVALID)) ? rsis_pkg::K_INVALID
                                                      : rsis_pkg::kind_t'(kind);
        align_low  = telem_reg.align < align_min_reg;
        press_bad  = (telem_reg.press < press_min_reg) || (telem_reg.press > press_max_reg);
        locked_out = (telem_reg.mode == rsis_pkg::MODE_ABORT) ||
                     (telem_reg.mode == rsis_pkg::MODE_FAULT);
        value_ok   = !value[rsis_pkg::VALUE_W-1] &&
                     (value[rsis_pkg::VALUE_W-2:0] <= rsis_pkg::SETTING_MAX);
        fuel_sum   = (telem_reg.fuel < fuel_full_reg)
                   ? ({1'b0, telem_reg.fuel} + {1'b0, fuel_step_reg})
                   : {1'b0, telem_reg.fuel};

        telem_next = telem_reg;
        resp       = rsis_pkg::RESP_NONE;
        ev_we      = 1'b0;
        ev_code    = rsis_pkg::EV_NONE;

        case (k)
            rsis_pkg::K_TICK:
            begin
                if (telem_reg.mode == rsis_pkg::MODE_REFUEL)
                begin
                    if (align_low)
                    begin
                        telem_next.mode  = rsis_pkg::MODE_ABORT;
                        telem_next.gate  = 1'b0;
                        telem_next.cause = rsis_pkg::CAUSE_ALIGN_LOST;
                        ev_we = 1'b1;  ev_code = rsis_pkg::EV_ABORT_ALIGN;
                        resp  = rsis_pkg::RESP_ABORTED;
                    end
                    else if (press_bad)
                    begin
                        telem_next.mode  = rsis_pkg::MODE_ABORT;
                        telem_next.gate  = 1'b0;
                        telem_next.cause = rsis_pkg::CAUSE_PRESSURE;
                        ev_we = 1'b1;  ev_code = rsis_pkg::EV_ABORT_PRESS;
                        resp  = rsis_pkg::RESP_ABORTED;
                    end
                    else if (fuel_sum >= {1'b0, fuel_full_reg})
                    begin
                        telem_next.fuel = fuel_full_reg;
                        telem_next.gate = 1'b0;
                        telem_next.mode = rsis_pkg::MODE_COMPLETE;
                        ev_we = 1'b1;  ev_code = rsis_pkg::EV_COMPLETE;
                        resp  = rsis_pkg::RESP_COMPLETE;
                    end
                    else
                    begin
                        telem_next.fuel = fuel_sum[rsis_pkg::LEVEL_W-1:0];
                    end
                end
            end
            rsis_pkg::K_PING:   resp = rsis_pkg::RESP_PING;
            rsis_pkg::K_STATUS: resp = rsis_pkg::RESP_NONE;
            rsis_pkg::K_LOG:    resp = rsis_pkg::RESP_LOG;
            rsis_pkg::K_EMPTY:  resp = rsis_pkg::RESP_EMPTY;
            rsis_pkg::K_RESET:
            begin
                telem_next.mode  = rsis_pkg::MODE_SAFE;
                telem_next.align = rsis_pkg::ALIGN_RST;
                telem_next.press = rsis_pkg::PRESS_RST;
                telem_next.fuel  = '0;
                telem_next.dock  = 1'b0;
                telem_next.gate  = 1'b0;
                telem_next.cause = rsis_pkg::CAUSE_NONE;
                ev_we = 1'b1;  ev_code = rsis_pkg::EV_RESET;
                resp  = rsis_pkg::RESP_RESET;
            end
            rsis_pkg::K_SET_ALIGN:
            begin
                if (!has_value)
                    resp = rsis_pkg::RESP_ALIGN_NO_VALUE;
                else if (!value_ok)
                    resp = rsis_pkg::RESP_ALIGN_RANGE;
                else
                begin
                    telem_next.align = value[rsis_pkg::LEVEL_W-1:0];
                    resp = rsis_pkg::RESP_ALIGN_SET;
                end
            end
            rsis_pkg::K_SET_PRESS:
            begin
                if (!has_value)
                    resp = rsis_pkg::RESP_PRESS_NO_VALUE;
                else if (!value_ok)
                    resp = rsis_pkg::RESP_PRESS_RANGE;
                else
                begin
                    telem_next.press = value[rsis_pkg::LEVEL_W-1:0];
                    resp = rsis_pkg::RESP_PRESS_SET;
                end
            end
            rsis_pkg::K_ABORT:
            begin
                telem_next.mode  = rsis_pkg::MODE_ABORT;
                telem_next.gate  = 1'b0;
                telem_next.cause = has_value ? rsis_pkg::CAUSE_CUSTOM
                                             : rsis_pkg::CAUSE_SUPERVISOR;
                ev_we   = 1'b1;
                ev_code = has_value ? rsis_pkg::EV_ABORT_CUSTOM : rsis_pkg::EV_ABORT_SUPER;
                resp    = rsis_pkg::RESP_ABORTED;
            end
            rsis_pkg::K_INJECT:
            begin
                telem_next.mode  = rsis_pkg::MODE_FAULT;
                telem_next.gate  = 1'b0;
                telem_next.cause = rsis_pkg::CAUSE_MANUAL;
                ev_we = 1'b1;  ev_code = rsis_pkg::EV_FAULT_MANUAL;
                resp  = rsis_pkg::RESP_FAULTED;
            end
            rsis_pkg::K_APPROACH:
            begin
                if (locked_out)
                    resp = rsis_pkg::RESP_REFUSED;
                else if ((telem_reg.mode != rsis_pkg::MODE_IDLE) &&
                         (telem_reg.mode != rsis_pkg::MODE_SAFE))
                    resp = rsis_pkg::RESP_BAD_TRANSITION;
                else
                begin
                    telem_next.mode = rsis_pkg::MODE_APPROACH;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_APPROACH;
                    resp  = rsis_pkg::RESP_APPROACH;
                end
            end
            rsis_pkg::K_CHECK_ALIGN, rsis_pkg::K_LOCK:
            begin
                if (locked_out)
                    resp = rsis_pkg::RESP_REFUSED;
                else if ((k == rsis_pkg::K_CHECK_ALIGN) &&
                         (telem_reg.mode != rsis_pkg::MODE_APPROACH))
                    resp = rsis_pkg::RESP_NEED_APPROACH;
                else if ((k == rsis_pkg::K_LOCK) &&
                         (telem_reg.mode != rsis_pkg::MODE_ALIGN))
                    resp = rsis_pkg::RESP_NEED_ALIGN;
                else if (align_low)
                begin
                    telem_next.mode  = rsis_pkg::MODE_FAULT;
                    telem_next.gate  = 1'b0;
                    telem_next.cause = rsis_pkg::CAUSE_ALIGN_RANGE;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_FAULT_ALIGN;
                    resp  = rsis_pkg::RESP_FAULTED;
                end
                else if (k == rsis_pkg::K_CHECK_ALIGN)
                begin
                    telem_next.mode = rsis_pkg::MODE_ALIGN;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_ALIGN_OK;
                    resp  = rsis_pkg::RESP_ALIGN_OK;
                end
                else
                begin
                    telem_next.mode = rsis_pkg::MODE_DOCKED;
                    telem_next.dock = 1'b1;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_DOCKED;
                    resp  = rsis_pkg::RESP_LOCKED;
                end
            end
            rsis_pkg::K_OPEN_GATE:
            begin
                if (locked_out)
                    resp = rsis_pkg::RESP_REFUSED;
                else if (telem_reg.mode != rsis_pkg::MODE_DOCKED)
                    resp = rsis_pkg::RESP_GATE_BLOCKED;
                else
                begin
                    telem_next.mode = rsis_pkg::MODE_GATE;
                    telem_next.gate = 1'b1;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_GATE_OPEN;
                    resp  = rsis_pkg::RESP_GATE_OPEN;
                end
            end
            rsis_pkg::K_CHECK_PRESS:
            begin
                if (locked_out)
                    resp = rsis_pkg::RESP_REFUSED;
                else if (telem_reg.mode != rsis_pkg::MODE_GATE)
                    resp = rsis_pkg::RESP_NEED_GATE_OPEN;
                else if (press_bad)
                begin
                    telem_next.mode  = rsis_pkg::MODE_FAULT;
                    telem_next.gate  = 1'b0;
                    telem_next.cause = rsis_pkg::CAUSE_PRESSURE;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_FAULT_PRESS;
                    resp  = rsis_pkg::RESP_FAULTED;
                end
                else
                begin
                    telem_next.mode = rsis_pkg::MODE_PRESS;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_PRESS_OK;
                    resp  = rsis_pkg::RESP_PRESS_OK;
                end
            end
            rsis_pkg::K_START:
            begin
                if (locked_out)
                    resp = rsis_pkg::RESP_REFUSED;
                else if (telem_reg.mode != rsis_pkg::MODE_PRESS)
                    resp = rsis_pkg::RESP_NEED_PRESS;
                else if (!telem_reg.dock)
                    resp = rsis_pkg::RESP_NEED_DOCK;
                else if (!telem_reg.gate)
                    resp = rsis_pkg::RESP_NEED_GATE;
                else if (align_low)
                begin
                    telem_next.mode  = rsis_pkg::MODE_FAULT;
                    telem_next.gate  = 1'b0;
                    telem_next.cause = rsis_pkg::CAUSE_ALIGN_RANGE;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_FAULT_ALIGN;
                    resp  = rsis_pkg::RESP_FAULTED;
                end
                else
                begin
                    telem_next.mode = rsis_pkg::MODE_REFUEL;
                    telem_next.fuel = '0;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_REFUEL_START;
                    resp  = rsis_pkg::RESP_REFUEL_START;
                end
            end
            rsis_pkg::K_STOP:
            begin
                if (locked_out)
                    resp = rsis_pkg::RESP_REFUSED;
                else if (telem_reg.mode != rsis_pkg::MODE_REFUEL)
                    resp = rsis_pkg::RESP_NOT_REFUELING;
                else
                begin
                    telem_next.mode = rsis_pkg::MODE_SAFE;
                    telem_next.gate = 1'b0;
                    ev_we = 1'b1;  ev_code = rsis_pkg::EV_REFUEL_STOP;
                    resp  = rsis_pkg::RESP_STOPPED;
                end
            end
            default:
            begin
                resp = locked_out ? rsis_pkg::RESP_REFUSED : rsis_pkg::RESP_INVALID;
            end
        endcase

        log_wr.we   = step && ev_we;
        log_wr.code = ev_code;
    end

endmodule

`default_nettype wire

@@ design/rsis_log.sv @@
`default_nettype none

module rsis_log (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire rsis_pkg::log_wr_t                log_wr,
    input  wire logic                             rd_en,
    input  wire logic [rsis_pkg::LOG_AW-1:0]      rd_idx,
    output rsis_pkg::event_t                      rd_data,
    output logic [rsis_pkg::LOG_CW-1:0]           count
);

    localparam logic [rsis_pkg::LOG_AW:0] DEPTH_W = (rsis_pkg::LOG_AW + 1)'(rsis_pkg::LOG_DEPTH);
    localparam logic [rsis_pkg::LOG_CW-1:0] DEPTH_C = rsis_pkg::LOG_CW'(rsis_pkg::LOG_DEPTH);

    rsis_pkg::event_t                  mem [rsis_pkg::LOG_DEPTH];
    rsis_pkg::event_t                  q_reg;
    logic                              q_boot_reg;

    logic [rsis_pkg::LOG_AW-1:0]       head_reg;
    logic [rsis_pkg::LOG_AW-1:0]       head_next;
    logic [rsis_pkg::LOG_CW-1:0]       count_reg;
    logic [rsis_pkg::LOG_CW-1:0]       count_next;
    logic                              boot_reg;
    logic                              boot_next;
    logic                              full;
    logic [rsis_pkg::LOG_AW:0]         wr_sum;
    logic [rsis_pkg::LOG_AW:0]         rd_sum;
    logic [rsis_pkg::LOG_AW:0]         hd_sum;
    logic [rsis_pkg::LOG_AW-1:0]       wr_addr;
    logic [rsis_pkg::LOG_AW-1:0]       rd_addr;

    // Circular buffer: logical entry i lives at (head + i) wrapped to the depth
    always_comb
    begin
        full    = (count_reg == DEPTH_C);
        wr_sum  = {1'b0, head_reg} + {1'b0, rsis_pkg::LOG_AW'(count_reg)};
        rd_sum  = {1'b0, head_reg} + {1'b0, rd_idx};
        hd_sum  = {1'b0, head_reg} + (rsis_pkg::LOG_AW + 1)'(1);
        if (wr_sum >= DEPTH_W)
            wr_sum = wr_sum - DEPTH_W;
        if (rd_sum >= DEPTH_W)
            rd_sum = rd_sum - DEPTH_W;
        if (hd_sum >= DEPTH_W)
            hd_sum = hd_sum - DEPTH_W;
        rd_addr = rd_sum[rsis_pkg::LOG_AW-1:0];
        wr_addr = full ? head_reg : wr_sum[rsis_pkg::LOG_AW-1:0];

        head_next  = head_reg;
        count_next = count_reg;
        boot_next  = boot_reg;
        if (log_wr.we)
        begin
            if (full)
                head_next = hd_sum[rsis_pkg::LOG_AW-1:0];
            else
                count_next = count_reg + rsis_pkg::LOG_CW'(1);
            // the boot entry sits at slot zero until something overwrites it
            if (wr_addr == '0)
                boot_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= rsis_pkg::LOG_CW'(1);
            boot_reg  <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            boot_reg  <= boot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (log_wr.we)
            mem[wr_addr] <= log_wr.code;
        if (rd_en)
        begin
            q_reg      <= mem[rd_addr];
            q_boot_reg <= boot_reg && (rd_addr == '0);
        end
    end

    assign rd_data = q_boot_reg ? rsis_pkg::EV_BOOT : q_reg;
    assign count   = count_reg;

endmodule

`default_nettype wire

@@ design/rsis_checker.sv @@
`default_nettype none

module rsis_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic [rsis_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [rsis_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  wire logic                                m_axis_tlast
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // only a log readout spans several beats; other results carry no entry
    a_multi_is_log: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[4:0] != 5'(rsis_pkg::RESP_LOG)) |->
            m_axis_tlast && (m_axis_tdata[43:35] == 9'd0))
        else $error("non-log result not final or carries a log entry");

    // gate never shows open without the dock locked
    a_gate_needs_dock: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[31] |-> m_axis_tdata[30])
        else $error("gate open while dock unlocked");

    // no command is taken while a log readout is still running
    a_no_cmd_mid_log: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("command accepted during log readout");

    // an accepted log request is followed by tready dropping as the readout begins
    a_log_first: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tuser[4:0] == 5'(rsis_pkg::K_LOG)) |=> !s_axis_tready)
        else $error("log request did not start a readout");

endmodule

bind refuel_safety_interlock_sequencer rsis_checker u_rsis_checker (.*);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import rsis_pkg::*;

    // Command beats past the directed part, and the watchdog's patience in
    // cycles with no beat, no config write and no result moving.
    localparam int RANDOM_ITEMS = 90;
    localparam int STALL_LIMIT  = 2000;
    localparam int LEVEL_MAX    = 100;
    localparam int PHASE_ITEMS  = 24;

    // One result beat as the sequencer should emit it.
    typedef struct {
        resp_t              resp;
        mode_t              mode;
        logic [LEVEL_W-1:0] align;
        logic [LEVEL_W-1:0] press;
        logic [LEVEL_W-1:0] fuel;
        logic               dock;
        logic               gate;
        cause_t             cause;
        event_t             entry;
        logic [POS_W-1:0]   pos;
        logic               fin;
    } result_beat_t;

    // Interlock state mirror: tracks thresholds, telemetry and the event
    // history, turns every accepted command into the beats it must produce
    // and checks returned beats against them in order.
    class refuel_scoreboard;
        int           align_min, press_min, press_max, fuel_inc, fuel_full;
        mode_t        mode;
        int           align, press, fuel;
        bit           dock, gate;
        cause_t       cause;
        event_t       history[$];
        result_beat_t expected_q[$];
        int           errors;

        function new();
            align_min = ALIGN_MIN_RST;
            press_min = PRESS_MIN_RST;
            press_max = PRESS_MAX_RST;
            fuel_inc  = FUEL_STEP_RST;
            fuel_full = FUEL_FULL_RST;
            mode      = MODE_IDLE;
            align     = ALIGN_RST;
            press     = PRESS_RST;
            fuel      = 0;
            dock      = 0;
            gate      = 0;
            cause     = CAUSE_NONE;
            history.push_back(EV_BOOT);
            errors    = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, int v);
            case (idx)
                CFG_ALIGN_MIN: align_min = v;
                CFG_PRESS_MIN: press_min = v;
                CFG_PRESS_MAX: press_max = v;
                CFG_FUEL_STEP: fuel_inc  = v;
                CFG_FUEL_FULL: fuel_full = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Shift log: drop the oldest code once full.
        function void record_event(event_t ev);
            history.push_back(ev);
            if (history.size() > LOG_DEPTH)
                void'(history.pop_front());
        endfunction

        function resp_t enter_abort(cause_t c, event_t ev);
            mode  = MODE_ABORT;
            gate  = 0;
            cause = c;
            record_event(ev);
            return RESP_ABORTED;
        endfunction

        function resp_t enter_fault(cause_t c, event_t ev);
            mode  = MODE_FAULT;
            gate  = 0;
            cause = c;
            record_event(ev);
            return RESP_FAULTED;
        endfunction

        function bit pressure_out();
            return press < press_min || press > press_max;
        endfunction

        // Refuel clock: safety check first, then add fuel and clamp at full.
        function resp_t refuel_tick();
            if (mode != MODE_REFUEL)
                return RESP_NONE;
            if (align < align_min)
                return enter_abort(CAUSE_ALIGN_LOST, EV_ABORT_ALIGN);
            if (pressure_out())
                return enter_abort(CAUSE_PRESSURE, EV_ABORT_PRESS);
            if (fuel < fuel_full)
                fuel += fuel_inc;
            if (fuel >= fuel_full)
            begin
                fuel = fuel_full;
                gate = 0;
                mode = MODE_COMPLETE;
                record_event(EV_COMPLETE);
                return RESP_COMPLETE;
            end
            return RESP_NONE;
        endfunction

        function void push_beat(resp_t r, event_t ev, int pos, bit fin);
            result_beat_t b;
            b.resp  = r;
            b.mode  = mode;
            b.align = LEVEL_W'(align);
            b.press = LEVEL_W'(press);
            b.fuel  = LEVEL_W'(fuel);
            b.dock  = dock;
            b.gate  = gate;
            b.cause = cause;
            b.entry = ev;
            b.pos   = POS_W'(pos);
            b.fin   = fin;
            expected_q.push_back(b);
        endfunction

        // Note one accepted command beat and queue the beats it causes.
        function void note_command(logic [KIND_W-1:0] raw, logic [VALUE_W-1:0] v, bit has);
            kind_t k;
            int    val;
            resp_t r;
            k   = (raw > K_INVALID) ? K_INVALID : kind_t'(raw);
            val = $signed(v);
            if (k == K_LOG)
            begin
                foreach (history[i])
                    push_beat(RESP_LOG, history[i], i, i == history.size() - 1);
                return;
            end
            case (k)
                K_TICK:   r = refuel_tick();
                K_EMPTY:  r = RESP_EMPTY;
                K_PING:   r = RESP_PING;
                K_STATUS: r = RESP_NONE;
                K_RESET:
                begin
                    mode  = MODE_SAFE;
                    align = ALIGN_RST;
                    press = PRESS_RST;
                    fuel  = 0;
                    dock  = 0;
                    gate  = 0;
                    cause = CAUSE_NONE;
                    record_event(EV_RESET);
                    r = RESP_RESET;
                end
                K_SET_ALIGN:
                    if (!has)
                        r = RESP_ALIGN_NO_VALUE;
                    else if (val < 0 || val > LEVEL_MAX)
                        r = RESP_ALIGN_RANGE;
                    else
                    begin
                        align = val;
                        r = RESP_ALIGN_SET;
                    end
                K_SET_PRESS:
                    if (!has)
                        r = RESP_PRESS_NO_VALUE;
                    else if (val < 0 || val > LEVEL_MAX)
                        r = RESP_PRESS_RANGE;
                    else
                    begin
                        press = val;
                        r = RESP_PRESS_SET;
                    end
                K_ABORT:
                    r = has ? enter_abort(CAUSE_CUSTOM, EV_ABORT_CUSTOM)
                            : enter_abort(CAUSE_SUPERVISOR, EV_ABORT_SUPER);
                K_INJECT: r = enter_fault(CAUSE_MANUAL, EV_FAULT_MANUAL);
                default:
                    if (mode == MODE_ABORT || mode == MODE_FAULT)
                        r = RESP_REFUSED;
                    else
                        case (k)
                            K_APPROACH:
                                if (mode != MODE_IDLE && mode != MODE_SAFE)
                                    r = RESP_BAD_TRANSITION;
                                else
                                begin
                                    mode = MODE_APPROACH;
                                    record_event(EV_APPROACH);
                                    r = RESP_APPROACH;
                                end
                            K_CHECK_ALIGN:
                                if (mode != MODE_APPROACH)
                                    r = RESP_NEED_APPROACH;
                                else
                                begin
                                    mode = MODE_ALIGN;
                                    if (align < align_min)
                                        r = enter_fault(CAUSE_ALIGN_RANGE, EV_FAULT_ALIGN);
                                    else
                                    begin
                                        record_event(EV_ALIGN_OK);
                                        r = RESP_ALIGN_OK;
                                    end
                                end
                            K_LOCK:
                                if (mode != MODE_ALIGN)
                                    r = RESP_NEED_ALIGN;
                                else if (align < align_min)
                                    r = enter_fault(CAUSE_ALIGN_RANGE, EV_FAULT_ALIGN);
                                else
                                begin
                                    dock = 1;
                                    mode = MODE_DOCKED;
                                    record_event(EV_DOCKED);
                                    r = RESP_LOCKED;
                                end
                            K_OPEN_GATE:
                                if (mode != MODE_DOCKED)
                                    r = RESP_GATE_BLOCKED;
                                else
                                begin
                                    gate = 1;
                                    mode = MODE_GATE;
                                    record_event(EV_GATE_OPEN);
                                    r = RESP_GATE_OPEN;
                                end
                            K_CHECK_PRESS:
                                if (mode != MODE_GATE)
                                    r = RESP_NEED_GATE_OPEN;
                                else if (pressure_out())
                                    r = enter_fault(CAUSE_PRESSURE, EV_FAULT_PRESS);
                                else
                                begin
                                    mode = MODE_PRESS;
                                    record_event(EV_PRESS_OK);
                                    r = RESP_PRESS_OK;
                                end
                            K_START:
                                if (mode != MODE_PRESS)
                                    r = RESP_NEED_PRESS;
                                else if (!dock)
                                    r = RESP_NEED_DOCK;
                                else if (!gate)
                                    r = RESP_NEED_GATE;
                                else if (align < align_min)
                                    r = enter_fault(CAUSE_ALIGN_RANGE, EV_FAULT_ALIGN);
                                else
                                begin
                                    mode = MODE_REFUEL;
                                    fuel = 0;
                                    record_event(EV_REFUEL_START);
                                    r = RESP_REFUEL_START;
                                end
                            K_STOP:
                                if (mode != MODE_REFUEL)
                                    r = RESP_NOT_REFUELING;
                                else
                                begin
                                    mode = MODE_SAFE;
                                    gate = 0;
                                    record_event(EV_REFUEL_STOP);
                                    r = RESP_STOPPED;
                                end
                            default: r = RESP_INVALID;
                        endcase
            endcase
            push_beat(r, EV_NONE, 0, 1);
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        // Check one returned beat against the oldest expectation.
        function void check_beat(logic [OUT_TDATA_W-1:0] d, logic tl);
            result_beat_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat: expected none, actual %h",
                         $time, d);
                return;
            end
            e = expected_q.pop_front();
            compare("response",      32'(e.resp),  32'(d[4:0]));
            compare("mode",          32'(e.mode),  32'(d[8:5]));
            compare("alignment_now", 32'(e.align), 32'(d[15:9]));
            compare("pressure_now",  32'(e.press), 32'(d[22:16]));
            compare("fuel_level",    32'(e.fuel),  32'(d[29:23]));
            compare("dock",          32'(e.dock),  32'(d[30]));
            compare("gate_is_open",  32'(e.gate),  32'(d[31]));
            compare("fault_cause",   32'(e.cause), 32'(d[34:32]));
            compare("log_entry",     32'(e.entry), 32'(d[39:35]));
            compare("log_position",  32'(e.pos),   32'(d[43:40]));
            compare("last",          32'(e.fin),   32'(tl));
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;   // value[9:0], zero pad
    logic [IN_TUSER_W-1:0]   s_axis_tuser;   // kind[4:0], has_value[5]
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // response, mode, alignment, pressure, fuel, dock, gate, cause,
    // log_entry, log_position from bit 0 up, zero pad
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    m_axis_tlast;
    logic                    cfg_wen;
    logic [CFG_AW-1:0]       cfg_addr;
    logic [LEVEL_W-1:0]      cfg_wdata;

    refuel_scoreboard sb = new();

    // Random gaps on both sides; cleared for one whole phase so that
    // back-to-back beats get their own stretch.
    bit idle_on = 1'b1;
    int cmd_count = 0;
    int stall_cycles = 0;

    refuel_safety_interlock_sequencer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Result sink: check every accepted beat, then pick the next tready.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= !(idle_on && $urandom_range(99) < 6);
    end

    // Watchdog: bail out when nothing moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_wen)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one command beat, hold it until accepted, then note it.
    // Leave tvalid high; the next call or drain() decides what follows.
    task automatic send_cmd(input logic [KIND_W-1:0] kind, input int value, input logic has);
        while (idle_on && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - VALUE_W){1'b0}}, VALUE_W'(value)};
        s_axis_tuser  <= {has, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(kind, VALUE_W'(value), has);
        cmd_count++;
    endtask

    // Random command of any kind, defined or not, with random argument.
    task automatic noise();
        send_cmd(KIND_W'($urandom_range(31)), int'($urandom_range(1023)),
                 1'($urandom_range(1)));
    endtask

    // Well-formed step, now and then preceded by a stray command.
    task automatic send_step(input kind_t k, input int value, input logic has);
        if ($urandom_range(99) < 12)
            noise();
        send_cmd(k, value, has);
    endtask

    // Drop tvalid and wait for every expected beat to come back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write all five thresholds, one per cycle, block idle.
    task automatic program_regs(input int am, input int pmin, input int pmax,
                                input int inc, input int full);
        cfg_idx_t slot[5];
        int       vals[5];
        slot = '{CFG_ALIGN_MIN, CFG_PRESS_MIN, CFG_PRESS_MAX, CFG_FUEL_STEP, CFG_FUEL_FULL};
        vals = '{am, pmin, pmax, inc, full};
        foreach (slot[i])
        begin
            cfg_wen   <= 1'b1;
            cfg_addr  <= slot[i];
            cfg_wdata <= LEVEL_W'(vals[i]);
            @(posedge clk);
            sb.set_reg(slot[i], vals[i]);
        end
        cfg_wen <= 1'b0;
    endtask

    // One docking run: usually reset to safe, maybe retune alignment and
    // pressure, walk the interlock chain (skipping a step now and then), tick
    // until the run ends or the step budget runs out, and sometimes read back the log.
    task automatic refuel_session();
        kind_t chain[6];
        int    pick;
        int    ticks;
        chain = '{K_APPROACH, K_CHECK_ALIGN, K_LOCK, K_OPEN_GATE, K_CHECK_PRESS, K_START};
        if ($urandom_range(99) < 90)
            send_step(K_RESET, $urandom_range(1023), 1'($urandom_range(1)));
        if ($urandom_range(99) < 60)
            send_step(K_SET_ALIGN,
                      ($urandom_range(99) < 85) ? $urandom_range(LEVEL_MAX, sb.align_min)
                                                : $urandom_range(1023),
                      $urandom_range(99) < 95);
        if ($urandom_range(99) < 60)
            send_step(K_SET_PRESS,
                      ($urandom_range(99) < 85) ? $urandom_range(sb.press_max, sb.press_min)
                                                : $urandom_range(1023),
                      $urandom_range(99) < 95);
        foreach (chain[i])
            if ($urandom_range(99) >= 5)
                send_step(chain[i], $urandom_range(1023), 1'($urandom_range(1)));
        ticks = 0;
        while (sb.mode == MODE_REFUEL && ticks < 16)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                send_step(K_STOP, $urandom_range(1023), 1'($urandom_range(1)));
            else if (pick < 8)
                send_step(K_SET_ALIGN, $urandom_range(LEVEL_MAX), 1'b1);
            else if (pick < 12)
                send_step(K_SET_PRESS, $urandom_range(LEVEL_MAX), 1'b1);
            else if (pick < 14)
                send_step(K_ABORT, $urandom_range(1023), 1'($urandom_range(1)));
            else
                send_step(K_TICK, $urandom_range(1023), 1'($urandom_range(1)));
            ticks++;
        end
        if ($urandom_range(99) < 30)
            send_step(K_LOG, $urandom_range(1023), 1'($urandom_range(1)));
    endtask

    initial
    begin : stimulus
        int phase;
        int phase_end;
        int directed_items;
        int am, pmin, pmax, inc, full;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_wen       <= 1'b0;
        cfg_addr      <= CFG_ALIGN_MIN;
        cfg_wdata     <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass on the reset thresholds.
        send_cmd(K_LOG, 0, 1'b0);                 // boot entry only
        send_cmd(K_TICK, 0, 1'b0);                // quiet tick outside refueling
        send_cmd(K_PING, 0, 1'b0);
        send_cmd(K_STATUS, 0, 1'b1);
        send_cmd(K_EMPTY, 0, 1'b0);
        send_cmd(K_INVALID, 0, 1'b0);
        send_cmd({KIND_W{1'b1}}, -1, 1'b1);       // unknown kind acts as invalid
        send_cmd(K_CHECK_ALIGN, 0, 1'b0);         // out of order from idle
        send_cmd(K_SET_ALIGN, 70, 1'b0);          // argument missing
        send_cmd(K_SET_ALIGN, -512, 1'b1);        // negative, refused
        send_cmd(K_SET_PRESS, 511, 1'b1);         // above range, refused
        send_cmd(K_SET_PRESS, 0, 1'b0);           // argument missing
        send_cmd(K_SET_PRESS, 0, 1'b1);           // below pressure_min
        send_cmd(K_SET_ALIGN, 100, 1'b1);
        send_cmd(K_APPROACH, 0, 1'b0);
        send_cmd(K_APPROACH, 0, 1'b0);            // bad transition
        send_cmd(K_CHECK_ALIGN, 0, 1'b0);
        send_cmd(K_LOCK, 0, 1'b0);
        send_cmd(K_OPEN_GATE, 0, 1'b0);
        send_cmd(K_CHECK_PRESS, 0, 1'b0);         // pressure fault
        send_cmd(K_START, 0, 1'b0);               // refused in fault
        send_cmd(K_TICK, 0, 1'b0);                // quiet tick in fault
        send_cmd(K_RESET, 0, 1'b0);               // safe, log kept
        send_cmd(K_ABORT, 5, 1'b1);               // custom cause
        send_cmd(K_INJECT, 0, 1'b0);
        send_cmd(K_ABORT, 0, 1'b0);               // supervisor cause
        send_cmd(K_LOG, 0, 1'b0);
        directed_items = cmd_count;

        // Random phases: extremes first, then an inverted pressure window
        // with single-tick fills, then random thresholds; one phase runs
        // with no gaps on either side.
        phase = 0;
        while (cmd_count < directed_items + RANDOM_ITEMS)
        begin
            drain();
            case (phase)
                0: program_regs(LEVEL_MAX, 0, LEVEL_MAX, LEVEL_MAX, LEVEL_MAX);
                1: program_regs(0, LEVEL_MAX, 0, 1, 1);
                default:
                begin
                    am   = $urandom_range(LEVEL_MAX);
                    pmin = $urandom_range(60);
                    pmax = $urandom_range(LEVEL_MAX, pmin);
                    full = $urandom_range(LEVEL_MAX, 1);
                    inc  = $urandom_range(full, (full + 5) / 6);
                    program_regs(am, pmin, pmax, inc, full);
                end
            endcase
            idle_on   = (phase != 1);
            phase_end = cmd_count + PHASE_ITEMS;
            while (cmd_count < phase_end)
                refuel_session();
            phase++;
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
